>>> rtl/cae_pkg.sv
// Shared constants, types and arithmetic helpers for the curved ADSR envelope.
// Used by the channel interfaces, the interpolation unit and the top level.
package cae_pkg;

   // default curve depth, entries per segment table
   localparam int CURVE_DEPTH = 256;

   // field widths
   localparam int MODE_W     = 2;
   localparam int SEL_W      = 2;
   localparam int INDEX_W    = 8;
   localparam int Q15_W      = 16;
   localparam int PHASE_W    = 3;
   localparam int PROG_W     = 25;
   localparam int FRAC_W     = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;

   // fixed point units
   localparam logic [Q15_W-1:0]  ONE_Q15 = 16'd32768;
   localparam logic [PROG_W-1:0] ONE_Q24 = 25'd16777216;

   // item modes
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GATE_ON  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GATE_OFF = 2'd2;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd3;

   // curve table selects
   localparam logic [SEL_W-1:0] TBL_ATTACK  = 2'd0;
   localparam logic [SEL_W-1:0] TBL_DECAY   = 2'd1;
   localparam logic [SEL_W-1:0] TBL_RELEASE = 2'd2;

   // envelope phases as reported on the result channel
   localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
   localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_INC  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_INC   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_INC = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN     = 2'd3;

   // configuration reset values
   localparam logic [PROG_W-1:0] INC_RESET     = 25'd65536;
   localparam logic [Q15_W-1:0]  SUSTAIN_RESET = 16'd16384;

   // stage loads for the interpolation unit
   typedef struct packed {
      logic load_pos;
      logic load_prod0;
      logic load_shape;
   } cae_shape_ctrl_type;

   // clamp an 18-bit Q1.15 value to 1.0
   function automatic logic [Q15_W-1:0] sat_q15(input logic [17:0] v);
      logic [Q15_W-1:0] r;
      r = (v > 18'(ONE_Q15)) ? ONE_Q15 : v[Q15_W-1:0];
      return r;
   endfunction

   // rounded Q1.15 product: (a * b + 0.5) >> 15
   function automatic logic [17:0] q15_mul(input logic [Q15_W-1:0] a,
                                           input logic [Q15_W-1:0] b);
      logic [32:0] p;
      p = 33'(a) * 33'(b) + 33'd16384;
      return p[32:15];
   endfunction

endpackage

>>> rtl/cae_if.sv
// Valid/ready channel interfaces for envelope request and result items.
// Field widths come from cae_pkg.
interface cae_req_if;
   logic                         valid;
   logic                         ready;
   logic [cae_pkg::MODE_W-1:0]   mode;
   logic [cae_pkg::SEL_W-1:0]    table_select;
   logic [cae_pkg::INDEX_W-1:0]  table_index;
   logic [cae_pkg::Q15_W-1:0]    table_value;

   modport source (output valid, output mode, output table_select, output table_index,
                   output table_value, input ready);
   modport sink (input valid, input mode, input table_select, input table_index,
                 input table_value, output ready);
endinterface

interface cae_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cae_pkg::Q15_W-1:0]    amplitude;
   logic [cae_pkg::PHASE_W-1:0]  phase;

   modport source (output valid, output amplitude, output phase, input ready);
   modport sink (input valid, input amplitude, input phase, output ready);
endinterface

>>> rtl/curved_adsr_envelope.sv
// Curved ADSR envelope: sequencer, envelope state, configuration and curve RAM.
// Uses cae_pkg, cae_if, cae_ram and cae_shaper.
// A tick that interpolates a curve passes the states EVAL, RD0, RD1, MIX, AMP and DONE,
// set by the two registered reads of the curve RAM and the two multiply stages;
// every other item passes EVAL and DONE only. One item is in flight; the next is accepted
// once its result has been loaded into the output register.
// Reset (synchronous): phase idle, amplitude and progress zero, registers at
// defaults. Curve RAM is not cleared and must be written before it is read.
module curved_adsr_envelope #(
   parameter int CURVE_DEPTH = cae_pkg::CURVE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   cae_req_if.sink                          req_ch,
   cae_rsp_if.source                        rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [cae_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cae_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int IDX_W = $clog2(CURVE_DEPTH);
   localparam int RAM_AW = IDX_W + cae_pkg::SEL_W;
   localparam int RAM_DEPTH = 1 << RAM_AW;
   localparam int Q = cae_pkg::Q15_W;
   localparam int P = cae_pkg::PROG_W;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_EVAL = 7'b0000010,
      ST_RD0  = 7'b0000100,
      ST_RD1  = 7'b0001000,
      ST_MIX  = 7'b0010000,
      ST_AMP  = 7'b0100000,
      ST_DONE = 7'b1000000
   } cae_state_type;

   cae_state_type state_ff, state_in;

   // held item
   logic [cae_pkg::MODE_W-1:0]  mode_ff;
   logic [cae_pkg::SEL_W-1:0]   sel_ff;
   logic [cae_pkg::INDEX_W-1:0] index_ff;
   logic [Q-1:0]                value_ff;
   logic [P:0]                  sum_ff, sum_in;

   // envelope state
   logic [cae_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [Q-1:0]                amp_ff, amp_in;
   logic [P-1:0]                prog_ff, prog_in;
   logic [Q-1:0]                atk_start_ff, atk_start_in;
   logic [Q-1:0]                rel_start_ff, rel_start_in;

   // configuration
   logic [P-1:0] atk_inc_ff, dec_inc_ff, rel_inc_ff;
   logic [Q-1:0] sus_lvl_ff;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [Q-1:0]                rsp_amp_ff;
   logic [cae_pkg::PHASE_W-1:0] rsp_phase_ff;

   logic                        req_fire;
   logic                        rsp_load;
   logic [P-1:0]                inc_sel;
   logic                        seg_end;
   logic                        shaped_seg;
   logic [Q-1:0]                sus;
   logic                        idx_ok;
   logic                        ram_wr_en;
   logic                        ram_rd_en;
   logic [RAM_AW-1:0]           ram_wr_addr;
   logic [RAM_AW-1:0]           ram_rd_addr;
   logic [Q-1:0]                ram_rd_data;
   logic [cae_pkg::SEL_W-1:0]   rd_tbl;
   logic [IDX_W-1:0]            index0, index1;
   logic [Q-1:0]                shape;
   logic [Q-1:0]                mul_a, mul_b;
   logic [17:0]                 mul_p;
   logic [17:0]                 amp_wide;
   cae_pkg::cae_shape_ctrl_type shape_ctrl;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign sus = (sus_lvl_ff > cae_pkg::ONE_Q15) ? cae_pkg::ONE_Q15 : sus_lvl_ff;

   // increment of the running segment
   always_comb begin
      case (phase_ff)
         cae_pkg::PH_ATTACK:  inc_sel = atk_inc_ff;
         cae_pkg::PH_DECAY:   inc_sel = dec_inc_ff;
         cae_pkg::PH_RELEASE: inc_sel = rel_inc_ff;
         default:             inc_sel = '0;
      endcase
   end

   assign seg_end    = (sum_ff[P:cae_pkg::FRAC_W] != '0);
   assign shaped_seg = (phase_ff == cae_pkg::PH_ATTACK) || (phase_ff == cae_pkg::PH_DECAY)
                    || (phase_ff == cae_pkg::PH_RELEASE);
   assign idx_ok     = (32'(index_ff) < 32'(CURVE_DEPTH));

   // curve table of the running segment
   always_comb begin
      case (phase_ff)
         cae_pkg::PH_DECAY:   rd_tbl = cae_pkg::TBL_DECAY;
         cae_pkg::PH_RELEASE: rd_tbl = cae_pkg::TBL_RELEASE;
         default:             rd_tbl = cae_pkg::TBL_ATTACK;
      endcase
   end

   // segment mix: one shared rounded Q1.15 multiply
   always_comb begin
      case (phase_ff)
         cae_pkg::PH_ATTACK: begin
            mul_a    = cae_pkg::ONE_Q15 - atk_start_ff;
            mul_b    = shape;
         end
         cae_pkg::PH_DECAY: begin
            mul_a    = cae_pkg::ONE_Q15 - sus;
            mul_b    = shape;
         end
         default: begin
            mul_a    = rel_start_ff;
            mul_b    = cae_pkg::ONE_Q15 - shape;
         end
      endcase
   end

   assign mul_p = cae_pkg::q15_mul(mul_a, mul_b);

   always_comb begin
      case (phase_ff)
         cae_pkg::PH_ATTACK: amp_wide = 18'(atk_start_ff) + mul_p;
         cae_pkg::PH_DECAY:  amp_wide = 18'(cae_pkg::ONE_Q15) - mul_p;
         default:            amp_wide = mul_p;
      endcase
   end

   // sequencer and envelope state update
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      phase_in     = phase_ff;
      amp_in       = amp_ff;
      prog_in      = prog_ff;
      atk_start_in = atk_start_ff;
      rel_start_in = rel_start_ff;
      shape_ctrl   = '0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = {rd_tbl, index1};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sum_in   = (P + 1)'(prog_ff) + (P + 1)'(inc_sel);
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_DONE;
            case (mode_ff)
               cae_pkg::MODE_TICK: begin
                  if (shaped_seg && !seg_end) begin
                     prog_in             = sum_ff[P-1:0];
                     shape_ctrl.load_pos = 1'b1;
                     state_in            = ST_RD0;
                  end else begin
                     case (phase_ff)
                        cae_pkg::PH_ATTACK: begin
                           phase_in = cae_pkg::PH_DECAY;
                           prog_in  = '0;
                           amp_in   = cae_pkg::ONE_Q15;
                        end
                        cae_pkg::PH_DECAY: begin
                           phase_in = cae_pkg::PH_SUSTAIN;
                           prog_in  = sum_ff[P-1:0];
                           amp_in   = sus;
                        end
                        cae_pkg::PH_SUSTAIN: begin
                           amp_in = sus;
                        end
                        cae_pkg::PH_RELEASE: begin
                           phase_in = cae_pkg::PH_IDLE;
                           prog_in  = sum_ff[P-1:0];
                           amp_in   = '0;
                        end
                        default: begin
                           phase_in = cae_pkg::PH_IDLE;
                           amp_in   = '0;
                        end
                     endcase
                  end
               end
               cae_pkg::MODE_GATE_ON: begin
                  atk_start_in = amp_ff;
                  prog_in      = '0;
                  phase_in     = cae_pkg::PH_ATTACK;
               end
               cae_pkg::MODE_GATE_OFF: begin
                  if ((phase_ff == cae_pkg::PH_ATTACK) || (phase_ff == cae_pkg::PH_DECAY)
                      || (phase_ff == cae_pkg::PH_SUSTAIN)) begin
                     rel_start_in = amp_ff;
                     prog_in      = '0;
                     phase_in     = cae_pkg::PH_RELEASE;
                  end
               end
               default: begin
                  ram_wr_en = idx_ok && (sel_ff inside {cae_pkg::TBL_ATTACK,
                                                        cae_pkg::TBL_DECAY,
                                                        cae_pkg::TBL_RELEASE});
               end
            endcase
         end
         ST_RD0: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = {rd_tbl, index0};
            state_in    = ST_RD1;
         end
         ST_RD1: begin
            ram_rd_en             = 1'b1;
            shape_ctrl.load_prod0 = 1'b1;
            state_in              = ST_MIX;
         end
         ST_MIX: begin
            shape_ctrl.load_shape = 1'b1;
            state_in              = ST_AMP;
         end
         ST_AMP: begin
            amp_in   = cae_pkg::sat_q15(amp_wide);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ram_wr_addr = {sel_ff, IDX_W'(index_ff)};

   // result register: hold until taken, reload on finish
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= cae_pkg::PH_IDLE;
         amp_ff       <= '0;
         prog_ff      <= '0;
         atk_start_ff <= '0;
         rel_start_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         amp_ff       <= amp_in;
         prog_ff      <= prog_in;
         atk_start_ff <= atk_start_in;
         rel_start_ff <= rel_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         atk_inc_ff <= cae_pkg::INC_RESET;
         dec_inc_ff <= cae_pkg::INC_RESET;
         rel_inc_ff <= cae_pkg::INC_RESET;
         sus_lvl_ff <= cae_pkg::SUSTAIN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cae_pkg::CSR_ATTACK_INC:  atk_inc_ff <= csr_wr_data[P-1:0];
            cae_pkg::CSR_DECAY_INC:   dec_inc_ff <= csr_wr_data[P-1:0];
            cae_pkg::CSR_RELEASE_INC: rel_inc_ff <= csr_wr_data[P-1:0];
            cae_pkg::CSR_SUSTAIN:     sus_lvl_ff <= csr_wr_data[Q-1:0];
            default: begin
            end
         endcase
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff  <= req_ch.mode;
         sel_ff   <= req_ch.table_select;
         index_ff <= req_ch.table_index;
         value_ff <= req_ch.table_value;
      end
      sum_ff <= sum_in;
      if (rsp_load) begin
         rsp_amp_ff   <= amp_ff;
         rsp_phase_ff <= phase_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.amplitude = rsp_amp_ff;
   assign rsp_ch.phase     = rsp_phase_ff;

   // curve tables, one quarter of the address space per segment
   cae_ram #(
      .WIDTH (Q),
      .DEPTH (RAM_DEPTH)
   ) u_curve_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (value_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cae_shaper #(
      .CURVE_DEPTH (CURVE_DEPTH)
   ) u_shaper (
      .clock    (clock),
      .ctrl     (shape_ctrl),
      .progress (sum_ff[cae_pkg::FRAC_W-1:0]),
      .rd_data  (ram_rd_data),
      .index0   (index0),
      .index1   (index1),
      .shape    (shape)
   );

endmodule

>>> rtl/cae_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cae_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and registered read when enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cae_shaper.sv
// Curve interpolation unit: table position, neighbor indexes and the
// two-product linear mix of the curve entries. Uses cae_pkg.
module cae_shaper #(
   parameter int CURVE_DEPTH = cae_pkg::CURVE_DEPTH
) (
   input  logic                                clock,
   input  cae_pkg::cae_shape_ctrl_type         ctrl,
   input  logic [cae_pkg::FRAC_W-1:0]          progress,
   input  logic [cae_pkg::Q15_W-1:0]           rd_data,
   output logic [$clog2(CURVE_DEPTH)-1:0]      index0,
   output logic [$clog2(CURVE_DEPTH)-1:0]      index1,
   output logic [cae_pkg::Q15_W-1:0]           shape
);

   localparam int IDX_W = $clog2(CURVE_DEPTH);
   localparam int POS_W = cae_pkg::FRAC_W + IDX_W;
   localparam int PROD_W = cae_pkg::Q15_W + cae_pkg::PROG_W;
   localparam int MIX_W = PROD_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CURVE_DEPTH - 1);

   logic [POS_W-1:0]                  pos_ff, pos_in;
   logic [PROD_W-1:0]                 prod0_ff, prod0_in;
   logic [cae_pkg::Q15_W-1:0]         shape_ff, shape_in;
   logic [cae_pkg::FRAC_W-1:0]        frac;
   logic [cae_pkg::PROG_W-1:0]        frac_c;
   logic [MIX_W-1:0]                  mix;

   // scale progress onto the table: integer part indexes, low bits weight
   assign pos_in = POS_W'(progress) * POS_W'(LAST_IDX);
   assign index0 = pos_ff[POS_W-1:cae_pkg::FRAC_W];
   assign index1 = (index0 < LAST_IDX) ? index0 + IDX_W'(1) : index0;
   assign frac   = pos_ff[cae_pkg::FRAC_W-1:0];
   assign frac_c = cae_pkg::ONE_Q24 - {1'b0, frac};

   // weight the lower entry, then add the weighted upper entry and round
   assign prod0_in = PROD_W'(rd_data) * PROD_W'(frac_c);
   assign mix = MIX_W'(prod0_ff) + MIX_W'(PROD_W'(rd_data) * PROD_W'(frac))
              + MIX_W'(25'd8388608);
   assign shape_in = cae_pkg::sat_q15(mix[MIX_W-1 -: 18]);

   always_ff @(posedge clock) begin
      if (ctrl.load_pos) begin
         pos_ff <= pos_in;
      end
      if (ctrl.load_prod0) begin
         prod0_ff <= prod0_in;
      end
      if (ctrl.load_shape) begin
         shape_ff <= shape_in;
      end
   end

   assign shape = shape_ff;

endmodule
